FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define ALLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ALLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/allp_pkg.sv
// shared types and constants of the allpass biquad cascade
package allp_pkg;

  localparam int MAX_STAGES_DEF      = 128;
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEFF_FRAC_BITS_DEF = 22;

  localparam int COEFF_BITS = 24;
  localparam int COUNT_BITS = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF_B0    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_B1    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_PASS = 2'd3;

  localparam logic signed [COEFF_BITS-1:0] B0_RESET    = 24'sd3777100;
  localparam logic signed [COEFF_BITS-1:0] B1_RESET    = -24'sd7960460;
  localparam logic [COUNT_BITS-1:0]        COUNT_RESET = 8'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic fin;
    logic clear;
    logic deliver;
  } ctrl_t;

endpackage

FILE: hw/rtl/allp_if.sv
// stream and configuration channel interfaces
interface allp_in_if import allp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface allp_out_if import allp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface allp_cfg_if import allp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/allp_ram.sv
// single-port-write, single-port-read history memory with registered read
module allp_ram import allp_pkg::*; #(
  parameter int DEPTH = 2 * MAX_STAGES_DEF,
  parameter int WIDTH = 2 * SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/allp_mac.sv
// section datapath: four products, accumulate, round, add x2, saturate
module allp_mac import allp_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  ctrl_t                           ctrl,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  input  logic signed [COEFF_BITS-1:0]    b0,
  input  logic signed [COEFF_BITS-1:0]    b1,
  input  logic        [2*SAMPLE_BITS-1:0] in_rd,
  input  logic        [2*SAMPLE_BITS-1:0] out_rd,
  output logic        [2*SAMPLE_BITS-1:0] in_wd,
  output logic        [2*SAMPLE_BITS-1:0] out_wd,
  output logic signed [SAMPLE_BITS-1:0]   x
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + COEFF_BITS;
  localparam int AW = PW + 2;
  localparam int TW = AW + 1;

  localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
  localparam logic signed [TW-1:0] SMAX = TW'({1'b0, {(SB-1){1'b1}}});
  localparam logic signed [TW-1:0] SMIN = -SMAX - TW'(1);

  logic signed [SB-1:0] x1, x2, y1, y2;
  logic signed [PW-1:0] p0, p1, p2, p3;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd_sum;
  logic signed [AW-1:0] quot;
  logic signed [TW-1:0] total;
  logic signed [SB-1:0] y_sat;

  assign x1 = in_rd[2*SB-1:SB];
  assign x2 = in_rd[SB-1:0];
  assign y1 = out_rd[2*SB-1:SB];
  assign y2 = out_rd[SB-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= sample_in;
    end else if (ctrl.fin) begin
      x <= y_sat;
    end
  end

  // one multiplier on each product path
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      p0 <= PW'(b0) * PW'(x);
      p1 <= PW'(b1) * PW'(x1);
      p2 <= PW'(b1) * PW'(y1);
      p3 <= PW'(b0) * PW'(y2);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      acc <= AW'(p0) + AW'(p1) - AW'(p2) - AW'(p3);
    end
  end

  // round half up, floor shift, then x2 at unit weight
  assign rnd_sum = acc + HALF;
  assign quot    = rnd_sum >>> COEFF_FRAC_BITS;
  assign total   = TW'(quot) + TW'(x2);

  always_comb begin
    if (total > SMAX) begin
      y_sat = SB'(SMAX);
    end else if (total < SMIN) begin
      y_sat = SB'(SMIN);
    end else begin
      y_sat = SB'(total);
    end
  end

  assign in_wd  = ctrl.clear ? '0 : {x, x1};
  assign out_wd = ctrl.clear ? '0 : {y_sat, y1};

endmodule

FILE: hw/rtl/allp_seq.sv
// sequencer: clearing pass, section walk over both banks, memory addressing
`include "assert_macros.svh"

module allp_seq import allp_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            out_free,
  input  logic [COUNT_BITS-1:0]           stage_count,
  input  logic                            double_pass,
  output ctrl_t                           ctrl,
  output logic                            rd_en,
  output logic [$clog2(2*MAX_STAGES)-1:0] rd_addr,
  output logic                            wr_en,
  output logic [$clog2(2*MAX_STAGES)-1:0] wr_addr
);

  localparam int DEPTH  = 2 * MAX_STAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STG_W  = $clog2(MAX_STAGES + 1);
  localparam int CNT_W  = (STG_W > COUNT_BITS) ? STG_W : COUNT_BITS;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [STG_W-1:0]   stage;
  logic               pass;
  logic [STG_W-1:0]   n_q;
  logic               dbl_q;

  logic [CNT_W-1:0]   cnt_ext;
  logic [STG_W-1:0]   n_eff;
  logic [STG_W-1:0]   stage_inc;
  logic               last_in_pass;
  logic               more_pass;
  logic               go_on;

  function automatic logic [ADDR_W-1:0] slot(input logic p, input logic [STG_W-1:0] s);
    return p ? ADDR_W'(MAX_STAGES) + ADDR_W'(s) : ADDR_W'(s);
  endfunction

  // counts above the bank size saturate
  assign cnt_ext      = CNT_W'(stage_count);
  assign n_eff        = (cnt_ext > CNT_W'(MAX_STAGES)) ? STG_W'(MAX_STAGES) : STG_W'(cnt_ext);
  assign stage_inc    = stage + STG_W'(1);
  assign last_in_pass = (stage_inc == n_q);
  assign more_pass    = !pass && dbl_q;
  assign go_on        = !last_in_pass || more_pass;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (n_eff == '0) ? ST_DONE : ST_MUL;
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_FIN;
      ST_FIN: begin
        state_next = go_on ? ST_MUL : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctrl         = '0;
    rd_en        = 1'b0;
    rd_addr      = slot(1'b0, '0);
    wr_en        = 1'b0;
    wr_addr      = slot(pass, stage);
    case (state)
      ST_CLEAR: begin
        ctrl.clear = 1'b1;
        wr_en      = 1'b1;
        wr_addr    = clr_addr;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        rd_en     = in_valid && (n_eff != '0);
      end
      ST_MUL: ctrl.mul = 1'b1;
      ST_SUM: ctrl.sum = 1'b1;
      ST_FIN: begin
        ctrl.fin = 1'b1;
        wr_en    = 1'b1;
        rd_en    = go_on;
        // fetch the next section while this one writes back
        rd_addr  = last_in_pass ? slot(1'b1, '0) : slot(pass, stage_inc);
      end
      ST_DONE: ctrl.deliver = out_free;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      stage    <= '0;
      pass     <= 1'b0;
      n_q      <= '0;
      dbl_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (ctrl.load) begin
        stage <= '0;
        pass  <= 1'b0;
        n_q   <= n_eff;
        dbl_q <= double_pass;
      end else if (ctrl.fin) begin
        if (!last_in_pass) begin
          stage <= stage_inc;
        end else if (more_pass) begin
          stage <= '0;
          pass  <= 1'b1;
        end
      end
    end
  end

  `ALLP_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> (state == ST_CLEAR), "no clear after reset")
  `ALLP_ASSERT(a_no_rw_collision, clk, rst, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit one entry")
  `ALLP_ASSERT(a_stage_in_range, clk, rst, (state == ST_MUL) |-> (stage < n_q), "section beyond count")
  `ALLP_ASSERT(a_second_pass_enabled, clk, rst, pass |-> dbl_q, "second bank used without double pass")

endmodule

FILE: hw/rtl/allpass_biquad_cascade.sv
// top level of the allpass biquad cascade
// Usage:
//   in_chan carries one signed sample per request (valid/ready). out_chan returns
//   exactly one saturated sample per accepted input, in order. cfg_chan writes
//   registers: 0 coeff_b0, 1 coeff_b1, 2 stage_count, 3 double_pass; its ready
//   is always high. Write configuration only while no sample is in flight.
// Sequence:
//   each section runs through ST_MUL (multiply), ST_SUM (accumulate) and ST_FIN
//   (round/saturate with write-back); sections run one after another, as each
//   depends on the one before and the history memories have a single write port.
//   N = min(stage_count, MAX_STAGES) sections run in each of P = 1 or 2 passes;
//   a new sample is taken only once the last one has gone to the output register.
// Reset:
//   rst restores the register reset values and starts a clearing pass over
//   all 2*MAX_STAGES entries that zeroes both history memories; in_chan ready
//   is low until it ends.
// Stall:
//   a result waits in the output register while out_chan is stalled; a new
//   sample is still accepted and runs, then holds until the register frees.
module allpass_biquad_cascade import allp_pkg::*; #(
  parameter int MAX_STAGES      = MAX_STAGES_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  allp_in_if.sink   in_chan,
  allp_out_if.source out_chan,
  allp_cfg_if.sink  cfg_chan
);

  localparam int DEPTH  = 2 * MAX_STAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HW     = 2 * SAMPLE_BITS;

  logic signed [COEFF_BITS-1:0]  coeff_b0;
  logic signed [COEFF_BITS-1:0]  coeff_b1;
  logic        [COUNT_BITS-1:0]  stage_count;
  logic                          double_pass;

  ctrl_t                         ctrl;
  logic                          rd_en, wr_en;
  logic        [ADDR_W-1:0]      rd_addr, wr_addr;
  logic        [HW-1:0]          in_rd, out_rd, in_wd, out_wd;
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_data;
  logic                          out_free;

  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid;
  assign out_chan.sample_out = out_data;
  assign out_free            = !out_valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_b0    <= B0_RESET;
      coeff_b1    <= B1_RESET;
      stage_count <= COUNT_RESET;
      double_pass <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_COEFF_B0:    coeff_b0    <= cfg_chan.data[COEFF_BITS-1:0];
        REG_COEFF_B1:    coeff_b1    <= cfg_chan.data[COEFF_BITS-1:0];
        REG_STAGE_COUNT: stage_count <= cfg_chan.data[COUNT_BITS-1:0];
        REG_DOUBLE_PASS: double_pass <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.deliver) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deliver) begin
      out_data <= x;
    end
  end

  allp_seq #(
    .MAX_STAGES (MAX_STAGES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .out_free    (out_free),
    .stage_count (stage_count),
    .double_pass (double_pass),
    .ctrl        (ctrl),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr)
  );

  allp_mac #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample_in (in_chan.sample_in),
    .b0        (coeff_b0),
    .b1        (coeff_b1),
    .in_rd     (in_rd),
    .out_rd    (out_rd),
    .in_wd     (in_wd),
    .out_wd    (out_wd),
    .x         (x)
  );

  // past inputs {x1, x2} of every section of both banks
  allp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (HW)
  ) u_in_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (in_rd)
  );

  // past outputs {y1, y2}
  allp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (HW)
  ) u_out_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (out_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_rd)
  );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench of the allpass biquad cascade with a bit-exact section predictor
`timescale 1ns / 1ps
module tb_top;
  import allp_pkg::*;

  localparam int     SLOTS        = 2 * MAX_STAGES_DEF;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 3 * MAX_STAGES_DEF * 2 + 8;
  localparam longint SAMPLE_MAX   = (longint'(1) <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
  localparam longint ROUND_HALF   = longint'(1) <<< (COEFF_FRAC_BITS_DEF - 1);

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]      coeff_t;
  typedef logic [CFG_DATA_W-1:0]             reg_data_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst;

  allp_in_if  in_chan ();
  allp_out_if out_chan ();
  allp_cfg_if cfg_chan ();

  allpass_biquad_cascade dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor copy of registers and section history
  coeff_t                model_b0;
  coeff_t                model_b1;
  logic [COUNT_BITS-1:0] model_stages;
  logic                  model_two_pass;
  sample_t               x1_hist [SLOTS];
  sample_t               x2_hist [SLOTS];
  sample_t               y1_hist [SLOTS];
  sample_t               y2_hist [SLOTS];

  sample_t     expected_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on demand
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no request pending, expected none, actual %0d",
               out_chan.sample_out);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_chan.sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_chan.sample_out);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void reset_model();
    model_b0       = B0_RESET;
    model_b1       = B1_RESET;
    model_stages   = COUNT_RESET;
    model_two_pass = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      x1_hist[i] = '0;
      x2_hist[i] = '0;
      y1_hist[i] = '0;
      y2_hist[i] = '0;
    end
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, reg_data_t data);
    case (idx)
      REG_COEFF_B0:    model_b0 = data[COEFF_BITS-1:0];
      REG_COEFF_B1:    model_b1 = data[COEFF_BITS-1:0];
      REG_STAGE_COUNT: model_stages = data[COUNT_BITS-1:0];
      REG_DOUBLE_PASS: model_two_pass = data[0];
      default: ;
    endcase
  endfunction

  function automatic sample_t run_section(int slot, sample_t x);
    longint  acc;
    longint  total;
    sample_t y;
    acc = longint'(model_b0) * longint'(x)
        + longint'(model_b1) * longint'(x1_hist[slot])
        - longint'(model_b1) * longint'(y1_hist[slot])
        - longint'(model_b0) * longint'(y2_hist[slot]);
    // round half up, then x2 joins with unit weight
    total = ((acc + ROUND_HALF) >>> COEFF_FRAC_BITS_DEF) + longint'(x2_hist[slot]);
    if (total > SAMPLE_MAX)
      y = sample_t'(SAMPLE_MAX);
    else if (total < SAMPLE_MIN)
      y = sample_t'(SAMPLE_MIN);
    else
      y = sample_t'(total);
    x2_hist[slot] = x1_hist[slot];
    y2_hist[slot] = y1_hist[slot];
    x1_hist[slot] = x;
    y1_hist[slot] = y;
    return y;
  endfunction

  function automatic sample_t filter_sample(sample_t x);
    int      n;
    int      passes;
    sample_t v;
    n      = (model_stages > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(model_stages);
    passes = model_two_pass ? 2 : 1;
    v      = x;
    for (int p = 0; p < passes; p++)
      for (int s = 0; s < n; s++)
        v = run_section(p * MAX_STAGES_DEF + s, v);
    return v;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5, 6:          return sample_t'(int'($urandom_range(2000)) - 1000);
      7, 8: begin
        case ($urandom_range(3))
          0:       return sample_t'(SAMPLE_MAX);
          1:       return sample_t'(SAMPLE_MIN);
          2:       return sample_t'(SAMPLE_MAX - 1);
          default: return sample_t'(SAMPLE_MIN + 1);
        endcase
      end
      default:       return '0;
    endcase
  endfunction

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 84;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 84;
      end
      default: begin
        send_idle_pct  = 7;
        recv_stall_pct = 7;
      end
    endcase
  endtask

  // valid stays high between back-to-back requests
  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid     <= 1'b1;
    in_chan.sample_in <= s;
    do @(posedge clk); while (!in_chan.ready);
    expected_samples.push_back(filter_sample(s));
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, reg_data_t data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    apply_register(idx, data);
  endtask

  task automatic configure(reg_data_t b0, reg_data_t b1, reg_data_t count,
                           reg_data_t two_pass);
    write_reg(REG_COEFF_B0, b0);
    write_reg(REG_COEFF_B1, b1);
    write_reg(REG_STAGE_COUNT, count);
    write_reg(REG_DOUBLE_PASS, two_pass);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    sample_t pattern [9] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF,
                             24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000};
    set_idle(IDLE_NONE);
    foreach (pattern[i]) send_sample(pattern[i]);
    wait_drained();
  endtask

  task automatic test_zero_stages();
    configure(B0_RESET, B1_RESET, 24'd0, 24'd0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    wait_drained();
    // second bank enabled but still no sections in use
    configure(B0_RESET, B1_RESET, 24'd0, 24'd1);
    send_sample(24'h123456);
    send_sample(-24'sd5);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    configure(24'h7FFFFF, 24'h800000, 24'd128, 24'd1);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    wait_drained();
    // count above the section limit saturates
    configure(24'h800000, 24'h7FFFFF, 24'd255, 24'd0);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000001);
    wait_drained();
  endtask

  task automatic test_wide_writes();
    // only the low bits of count and pass select are kept
    configure(B0_RESET, B1_RESET, 24'hABCD03, 24'hFFFFFE);
    send_sample(24'h400000);
    send_sample(24'h000000);
    send_sample(24'h000000);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    set_idle(IDLE_NONE);
    configure(B0_RESET, B1_RESET, 24'd2, 24'd1);
    hold_left = 300;
    repeat (8) send_sample(random_sample());
    wait_drained();
  endtask

  task automatic random_setup(output bit deep);
    reg_data_t b0;
    reg_data_t b1;
    reg_data_t count;
    int        b0_mag;
    int        b1_mag;
    int        pick;
    case ($urandom_range(3))
      0: begin
        // stable allpass: |b0| < 1, |b1| < 1 + b0
        b0_mag = $urandom_range(4194303);
        b1_mag = $urandom_range(4194303 + b0_mag);
        b0     = reg_data_t'(b0_mag);
        b1     = reg_data_t'($urandom_range(1) ? -b1_mag : b1_mag);
      end
      1: begin
        b0 = reg_data_t'($urandom);
        b1 = reg_data_t'($urandom);
      end
      2: begin
        case ($urandom_range(3))
          0:       b0 = 24'h7FFFFF;
          1:       b0 = 24'h800000;
          2:       b0 = 24'h000000;
          default: b0 = 24'h400000;
        endcase
        case ($urandom_range(3))
          0:       b1 = 24'h7FFFFF;
          1:       b1 = 24'h800000;
          2:       b1 = 24'h000000;
          default: b1 = 24'hC00000;
        endcase
      end
      default: begin
        b0 = B0_RESET;
        b1 = B1_RESET;
      end
    endcase
    count = reg_data_t'($urandom);
    pick  = $urandom_range(99);
    deep  = 1'b0;
    if (pick < 8) begin
      count[COUNT_BITS-1:0] = '0;
    end else if (pick < 14) begin
      deep                  = 1'b1;
      count[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(100, 255));
    end else begin
      count[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(1, 6));
    end
    configure(b0, b1, count, reg_data_t'($urandom));
  endtask

  task automatic test_random_traffic();
    bit deep;
    for (int m = 0; m < 4; m++) begin
      set_idle(idle_mode_t'(m));
      for (int seg = 0; seg < 5; seg++) begin
        random_setup(deep);
        repeat (deep ? 3 : 36) send_sample(random_sample());
        wait_drained();
      end
    end
    set_idle(IDLE_NONE);
  endtask

  initial begin
    rst               <= 1'b1;
    in_chan.valid     <= 1'b0;
    in_chan.sample_in <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= '0;
    cfg_chan.data     <= '0;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_stages();
    test_register_extremes();
    test_wide_writes();
    test_back_pressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/allp_pkg.sv
hw/rtl/allp_if.sv
hw/rtl/allp_ram.sv
hw/rtl/allp_mac.sv
hw/rtl/allp_seq.sv
hw/rtl/allpass_biquad_cascade.sv
tb/sv/tb_top.sv
